// File: sv/pid_position_loop_settle_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PID position loop checker
// ---------------------------------------------------------------------------
`ifndef PID_POSITION_LOOP_SETTLE_TOP_ASSERT_SVH
`define PID_POSITION_LOOP_SETTLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIDPLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pidpls: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PIDPLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pidpls: next-cycle check failed");

`endif

// File: sv/pidpls_pkg.sv
// ---------------------------------------------------------------------------
// pidpls_pkg
// Shared types and constants of the PID position loop.
// ---------------------------------------------------------------------------
package pidpls_pkg;

	localparam int SUM_WIDTH_DEF = 24;

	localparam int POS_W  = 16;
	localparam int GAIN_W = 16;
	localparam int BAND_W = 15;
	localparam int ERR_W  = 17;
	localparam int CHG_W  = 18;
	localparam int CFG_IDX_W = 3;
	localparam int DRIVE_W = 8;
	localparam int DRIVE_MAX = 100;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd6;

	// reset values: gains Q4.12, positions Q12.4
	localparam logic signed [POS_W-1:0] TARGET_RST = 16'sd0;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1413;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd328;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd614;
	localparam logic [BAND_W-1:0] WINDOW_RST = 15'd80;
	localparam logic [BAND_W-1:0] BAND_RST   = 15'd24;
	localparam logic INVERT_RST = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
	} gains_t;

	typedef struct packed {
		logic signed [POS_W-1:0] target;
		logic [BAND_W-1:0]       window;
		logic [BAND_W-1:0]       band;
		logic                    invert;
	} loop_cfg_t;

endpackage

// File: sv/pidpls_loop.sv
// ---------------------------------------------------------------------------
// pidpls_loop
// Loop state: error, windowed integral, derivative and settle latch.
// Updates once per accepted sample and hands the pre-update terms onward.
// ---------------------------------------------------------------------------
module pidpls_loop #(
	parameter int SUM_WIDTH = pidpls_pkg::SUM_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pidpls_pkg::loop_cfg_t                  cfg,
	input  logic                                   accept,
	input  logic signed [pidpls_pkg::POS_W-1:0]    measured_position,
	input  logic                                   start_req,
	output logic signed [pidpls_pkg::ERR_W-1:0]    snap_error,
	output logic signed [SUM_WIDTH-1:0]            snap_sum,
	output logic signed [pidpls_pkg::CHG_W-1:0]    snap_change,
	output logic                                   snap_done
);

	localparam int EW = pidpls_pkg::ERR_W;
	localparam int CW = pidpls_pkg::CHG_W;
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic signed [EW-1:0]        error_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [CW-1:0]        change_q;
	logic                        settled_q;

	logic signed [EW-1:0]        error_b;
	logic signed [SUM_WIDTH-1:0] sum_b;
	logic signed [CW-1:0]        change_b;
	logic                        settled_b;

	logic signed [EW-1:0]        err;
	logic [EW-1:0]               mag;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [CW-1:0]        change_next;
	logic                        settle_next;

	always_comb begin
		// start request clears the loop before the sample is used
		error_b   = start_req ? '0 : error_q;
		sum_b     = start_req ? '0 : sum_q;
		change_b  = start_req ? '0 : change_q;
		settled_b = start_req ? 1'b0 : settled_q;

		if (cfg.invert) begin
			err = {measured_position[15], measured_position} - {cfg.target[15], cfg.target};
		end else begin
			err = {cfg.target[15], cfg.target} - {measured_position[15], measured_position};
		end
		mag = err[EW-1] ? EW'(-err) : EW'(err);

		sum_wide = {sum_b[SUM_WIDTH-1], sum_b} + (SUM_WIDTH+1)'(err);
		if (mag >= {2'b00, cfg.window}) begin
			sum_next = '0;
		end else if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end

		change_next = {err[EW-1], err} - {error_b[EW-1], error_b};
		settle_next = settled_b || (mag < {2'b00, cfg.band});
	end

	assign snap_error  = error_b;
	assign snap_sum    = sum_b;
	assign snap_change = change_b;
	assign snap_done   = settle_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q   <= '0;
			sum_q     <= '0;
			change_q  <= '0;
			settled_q <= 1'b0;
		end else if (accept) begin
			if (settled_b) begin
				// hold the loop state while settled
				error_q   <= error_b;
				sum_q     <= sum_b;
				change_q  <= change_b;
				settled_q <= 1'b1;
			end else begin
				error_q   <= err;
				sum_q     <= sum_next;
				change_q  <= change_next;
				settled_q <= settle_next;
			end
		end
	end

endmodule

// File: sv/pidpls_drive.sv
// ---------------------------------------------------------------------------
// pidpls_drive
// Drive stage: state capture, then three gain products, sum, round and
// saturate straight into the result register.
// ---------------------------------------------------------------------------
module pidpls_drive #(
	parameter int SUM_WIDTH = pidpls_pkg::SUM_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pidpls_pkg::gains_t                        gains,
	input  logic                                      snap_valid,
	output logic                                      snap_ready,
	input  logic signed [pidpls_pkg::ERR_W-1:0]       snap_error,
	input  logic signed [SUM_WIDTH-1:0]               snap_sum,
	input  logic signed [pidpls_pkg::CHG_W-1:0]       snap_change,
	input  logic                                      snap_done,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [pidpls_pkg::DRIVE_W-1:0]     drive_pct,
	output logic                                      done_res
);

	localparam int EW   = pidpls_pkg::ERR_W;
	localparam int CW   = pidpls_pkg::CHG_W;
	localparam int GW   = pidpls_pkg::GAIN_W + 1;
	localparam int PPW  = EW + GW;
	localparam int PIW  = SUM_WIDTH + GW;
	localparam int PDW  = CW + GW;
	localparam int ACC_W = ((PIW > PDW) ? PIW : PDW) + 2;
	localparam int DW   = pidpls_pkg::DRIVE_W;
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(pidpls_pkg::DRIVE_MAX);
	localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(pidpls_pkg::DRIVE_MAX);
	localparam logic signed [DW-1:0] DRV_POS = DW'(pidpls_pkg::DRIVE_MAX);
	localparam logic signed [DW-1:0] DRV_NEG = -DW'(pidpls_pkg::DRIVE_MAX);

	logic v_s1, out_valid_q;
	logic rdy_o, rdy_s1;

	logic signed [EW-1:0]        error_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;
	logic signed [CW-1:0]        change_s1;
	logic                        done_s1;

	logic signed [PPW-1:0] prod_p;
	logic signed [PIW-1:0] prod_i;
	logic signed [PDW-1:0] prod_d;

	logic signed [DW-1:0] drive_q;
	logic                 done_q;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] whole;
	logic signed [DW-1:0]    drive_next;

	assign rdy_o      = !out_valid_q || out_ready;
	assign rdy_s1     = !v_s1 || rdy_o;
	assign snap_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= snap_valid;
			end
			if (rdy_o) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && snap_valid) begin
			error_s1  <= snap_error;
			sum_s1    <= snap_sum;
			change_s1 <= snap_change;
			done_s1   <= snap_done;
		end
		if (rdy_o && v_s1) begin
			drive_q <= drive_next;
			done_q  <= done_s1;
		end
	end

	// Q.16 sum, round half up to whole percent, clamp
	always_comb begin
		prod_p = PPW'(error_s1) * PPW'($signed({1'b0, gains.gain_p}));
		prod_i = PIW'(sum_s1) * PIW'($signed({1'b0, gains.gain_i}));
		prod_d = PDW'(change_s1) * PDW'($signed({1'b0, gains.gain_d}));
		acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d) + HALF;
		whole  = acc >>> 16;
		priority if (done_s1) begin
			drive_next = '0;
		end else if (whole > LIM_POS) begin
			drive_next = DRV_POS;
		end else if (whole < LIM_NEG) begin
			drive_next = DRV_NEG;
		end else begin
			drive_next = whole[DW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign drive_pct = drive_q;
	assign done_res  = done_q;

endmodule

// File: sv/pid_position_loop_settle_top.sv
// ---------------------------------------------------------------------------
// pid_position_loop_settle_top
// PID position loop with windowed integral and settle latch.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample per transaction:
//   measured_position (Q12.4) and start_req. Output channel
//   (out_valid/out_ready) returns one transaction per sample: drive_pct in
//   whole percent (-100..100) and done_res.
//   The loop state updates at the edge that accepts the sample, so the
//   next sample may follow in the very next cycle while in_ready is high:
//   one sample per cycle. Results pass state capture, then gain products,
//   sum and saturation into the output register that drives out_valid.
//   When the receiver stalls, results wait in the capture stage and the
//   output register; in_ready drops only once both are full.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data; the user
//   must do so only while the block is idle; the block does not enforce it.
//   Reset clears the loop state and loads register defaults.
// ---------------------------------------------------------------------------
module pid_position_loop_settle_top #(
	parameter int SUM_WIDTH = pidpls_pkg::SUM_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [pidpls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidpls_pkg::GAIN_W-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pidpls_pkg::POS_W-1:0]    measured_position,
	input  logic                                   start_req,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pidpls_pkg::DRIVE_W-1:0]  drive_pct,
	output logic                                   done_res
);

	pidpls_pkg::gains_t    gains_q;
	pidpls_pkg::loop_cfg_t loop_cfg_q;

	logic signed [pidpls_pkg::ERR_W-1:0] snap_error;
	logic signed [SUM_WIDTH-1:0]         snap_sum;
	logic signed [pidpls_pkg::CHG_W-1:0] snap_change;
	logic                                snap_done;
	logic                                snap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.gain_p    <= pidpls_pkg::GAIN_P_RST;
			gains_q.gain_i    <= pidpls_pkg::GAIN_I_RST;
			gains_q.gain_d    <= pidpls_pkg::GAIN_D_RST;
			loop_cfg_q.target <= pidpls_pkg::TARGET_RST;
			loop_cfg_q.window <= pidpls_pkg::WINDOW_RST;
			loop_cfg_q.band   <= pidpls_pkg::BAND_RST;
			loop_cfg_q.invert <= pidpls_pkg::INVERT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pidpls_pkg::CFG_TARGET: begin
					loop_cfg_q.target <= $signed(cfg_data);
				end
				pidpls_pkg::CFG_GAIN_P: begin
					gains_q.gain_p <= cfg_data;
				end
				pidpls_pkg::CFG_GAIN_I: begin
					gains_q.gain_i <= cfg_data;
				end
				pidpls_pkg::CFG_GAIN_D: begin
					gains_q.gain_d <= cfg_data;
				end
				pidpls_pkg::CFG_WINDOW: begin
					loop_cfg_q.window <= cfg_data[pidpls_pkg::BAND_W-1:0];
				end
				pidpls_pkg::CFG_BAND: begin
					loop_cfg_q.band <= cfg_data[pidpls_pkg::BAND_W-1:0];
				end
				pidpls_pkg::CFG_INVERT: begin
					loop_cfg_q.invert <= cfg_data[0];
				end
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign in_ready = snap_ready;

	pidpls_loop #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_loop (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (loop_cfg_q),
		.accept            (in_valid && snap_ready),
		.measured_position (measured_position),
		.start_req         (start_req),
		.snap_error        (snap_error),
		.snap_sum          (snap_sum),
		.snap_change       (snap_change),
		.snap_done         (snap_done)
	);

	pidpls_drive #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains_q),
		.snap_valid  (in_valid),
		.snap_ready  (snap_ready),
		.snap_error  (snap_error),
		.snap_sum    (snap_sum),
		.snap_change (snap_change),
		.snap_done   (snap_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_pct   (drive_pct),
		.done_res    (done_res)
	);

endmodule

// File: sv/pidpls_checker.sv
// ---------------------------------------------------------------------------
// pidpls_checker
// Port-level checks on the result channel of the PID position loop.
// ---------------------------------------------------------------------------
`include "pid_position_loop_settle_top_assert.svh"

module pidpls_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pidpls_pkg::DRIVE_W-1:0] drive_pct,
	input logic                                  done_res
);

	// settled loop never drives
	`PIDPLS_ASSERT_NOW(a_done_zero, out_valid && done_res, drive_pct == '0)

	// drive stays inside full scale
	`PIDPLS_ASSERT_NOW(a_drive_range, out_valid,
		drive_pct <= 8'sd100 && drive_pct >= -8'sd100)

	// stalled result holds
	`PIDPLS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(drive_pct) && $stable(done_res))

endmodule

bind pid_position_loop_settle_top pidpls_checker u_pidpls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive_pct (drive_pct),
	.done_res  (done_res)
);

// File: bench/tb_pid_position_loop_settle_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pid_position_loop_settle_top
// Self-checking bench for the PID position loop. A driver sends position
// samples over valid/ready with random gaps. A monitor takes results with
// random stalls and checks each one against a cycle-free model of the loop
// that runs on every accepted sample. The run goes through several register
// settings: reset defaults, saturating gains with a wide window, zero gains,
// and random mixes.
// ---------------------------------------------------------------------------
module tb_pid_position_loop_settle_top;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 7;
	localparam int PIPE_LAT = 2;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SUM_W = pidpls_pkg::SUM_WIDTH_DEF;
	localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint ACC_LIM = longint'(200) <<< 16;
	localparam logic [pidpls_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [pidpls_pkg::POS_W-1:0] meas;
		logic                                start;
	} sample_t;

	typedef struct packed {
		logic signed [pidpls_pkg::DRIVE_W-1:0] drive;
		logic                                  done;
	} loop_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [pidpls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pidpls_pkg::GAIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [pidpls_pkg::POS_W-1:0] measured_position = '0;
	logic start_req = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [pidpls_pkg::DRIVE_W-1:0] drive_pct;
	logic done_res;

	// loop model: register copies and state
	pidpls_pkg::gains_t gain_regs = '{gain_p: pidpls_pkg::GAIN_P_RST,
		gain_i: pidpls_pkg::GAIN_I_RST, gain_d: pidpls_pkg::GAIN_D_RST};
	pidpls_pkg::loop_cfg_t loop_regs = '{target: pidpls_pkg::TARGET_RST,
		window: pidpls_pkg::WINDOW_RST, band: pidpls_pkg::BAND_RST,
		invert: pidpls_pkg::INVERT_RST};
	logic signed [pidpls_pkg::ERR_W-1:0] prev_err = '0;
	logic signed [SUM_W-1:0] err_sum = '0;
	logic signed [pidpls_pkg::CHG_W-1:0] err_delta = '0;
	logic latched = 1'b0;

	sample_t sample_q[$];
	loop_result_t drive_expect[$];
	sample_t cur_sample;
	bit holding = 1'b0;
	int unsigned tx_wait = 0, tx_calm = 0;
	int unsigned rx_wait = 0, rx_calm = 0;
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;

	pid_position_loop_settle_top #(.SUM_WIDTH(SUM_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.measured_position(measured_position),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_pct(drive_pct),
		.done_res(done_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one loop tick: drive from the stored terms, then update them
	function automatic loop_result_t advance_loop(sample_t s);
		longint acc, lvl, e, mag, sum_next, d;
		loop_result_t r;
		lvl = 0;
		if (s.start) begin
			prev_err = '0;
			err_sum = '0;
			err_delta = '0;
			latched = 1'b0;
		end
		if (!latched) begin
			acc = longint'(prev_err) * longint'(gain_regs.gain_p)
				+ longint'(err_sum) * longint'(gain_regs.gain_i)
				+ longint'(err_delta) * longint'(gain_regs.gain_d);
			if (acc > ACC_LIM) acc = ACC_LIM;
			if (acc < -ACC_LIM) acc = -ACC_LIM;
			// round half up to whole percent
			lvl = (acc + 32768) >>> 16;
			if (lvl > pidpls_pkg::DRIVE_MAX) lvl = pidpls_pkg::DRIVE_MAX;
			if (lvl < -pidpls_pkg::DRIVE_MAX) lvl = -pidpls_pkg::DRIVE_MAX;
			if (loop_regs.invert)
				e = longint'($signed(s.meas)) - longint'($signed(loop_regs.target));
			else
				e = longint'($signed(loop_regs.target)) - longint'($signed(s.meas));
			mag = (e < 0) ? -e : e;
			if (mag < longint'(loop_regs.window)) begin
				sum_next = longint'(err_sum) + e;
				if (sum_next > SUM_HI) sum_next = SUM_HI;
				if (sum_next < SUM_LO) sum_next = SUM_LO;
				err_sum = sum_next[SUM_W-1:0];
			end else begin
				err_sum = '0;
			end
			d = e - longint'(prev_err);
			err_delta = d[pidpls_pkg::CHG_W-1:0];
			prev_err = e[pidpls_pkg::ERR_W-1:0];
			if (mag < longint'(loop_regs.band))
				latched = 1'b1;
		end
		if (latched)
			lvl = 0;
		r.drive = lvl[pidpls_pkg::DRIVE_W-1:0];
		r.done = latched;
		return r;
	endfunction

	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		// occasionally open a stretch with no idling at all
		if (roll < 2) begin
			calm = $urandom_range(20, 100);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] skew16(logic [15:0] lo, logic [15:0] hi,
		logic [15:0] typical);
		unique case ($urandom_range(0, 7))
			0: begin
				return lo;
			end
			1: begin
				return hi;
			end
			default: begin
				return typical;
			end
		endcase
	endfunction

	function automatic void add_sample(int pos, bit start);
		sample_t s;
		if (pos > 32767) pos = 32767;
		if (pos < -32768) pos = -32768;
		s.meas = pos[pidpls_pkg::POS_W-1:0];
		s.start = start;
		sample_q.push_back(s);
	endfunction

	task automatic write_reg(logic [pidpls_pkg::CFG_IDX_W-1:0] idx,
		logic [pidpls_pkg::GAIN_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			pidpls_pkg::CFG_TARGET: begin
				loop_regs.target = val;
			end
			pidpls_pkg::CFG_GAIN_P: begin
				gain_regs.gain_p = val;
			end
			pidpls_pkg::CFG_GAIN_I: begin
				gain_regs.gain_i = val;
			end
			pidpls_pkg::CFG_GAIN_D: begin
				gain_regs.gain_d = val;
			end
			pidpls_pkg::CFG_WINDOW: begin
				loop_regs.window = val[pidpls_pkg::BAND_W-1:0];
			end
			pidpls_pkg::CFG_BAND: begin
				loop_regs.band = val[pidpls_pkg::BAND_W-1:0];
			end
			pidpls_pkg::CFG_INVERT: begin
				loop_regs.invert = val[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic apply_config(logic [15:0] tgt, logic [15:0] gp, logic [15:0] gi,
		logic [15:0] gd, logic [15:0] win, logic [15:0] band, logic [15:0] inv);
		write_reg(pidpls_pkg::CFG_TARGET, tgt);
		write_reg(pidpls_pkg::CFG_GAIN_P, gp);
		write_reg(pidpls_pkg::CFG_GAIN_I, gi);
		write_reg(pidpls_pkg::CFG_GAIN_D, gd);
		write_reg(pidpls_pkg::CFG_WINDOW, win);
		write_reg(pidpls_pkg::CFG_BAND, band);
		write_reg(pidpls_pkg::CFG_INVERT, inv);
		// an index past the register list must change nothing
		write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic shuffle_config();
		logic [15:0] win, band;
		win = skew16(16'h0000, 16'h7FFF, 16'($urandom_range(0, 600)));
		band = skew16(16'h0000, 16'h7FFF, 16'($urandom_range(0, 200)));
		// upper bit lies beyond the register and is dropped
		win[15] = 1'($urandom_range(0, 1));
		band[15] = 1'($urandom_range(0, 1));
		apply_config(skew16(16'h8000, 16'h7FFF, 16'($urandom_range(0, 65535))),
			skew16(16'h0000, 16'hFFFF, 16'($urandom_range(0, 8191))),
			skew16(16'h0000, 16'hFFFF, 16'($urandom_range(0, 8191))),
			skew16(16'h0000, 16'hFFFF, 16'($urandom_range(0, 8191))),
			win, band, 16'($urandom_range(0, 65535)));
	endtask

	// mostly moves that close in on the target, some random noise between
	task automatic queue_random(int unsigned n);
		int unsigned cnt, steps, span, k;
		int off, aim;
		cnt = 0;
		aim = $signed(loop_regs.target);
		while (cnt < n) begin
			if ($urandom_range(0, 4) != 0) begin
				span = ($urandom_range(0, 9) < 7) ? 2000 : 65535;
				off = int'($urandom_range(0, 2 * span)) - int'(span);
				steps = $urandom_range(4, 20);
				add_sample(aim + off, $urandom_range(0, 9) != 0);
				for (k = 0; k < steps; k++) begin
					off = off * 3 / 4 + int'($urandom_range(0, 6)) - 3;
					add_sample(aim + off, 1'b0);
				end
				cnt += steps + 1;
			end else begin
				steps = $urandom_range(1, 6);
				for (k = 0; k < steps; k++)
					add_sample(int'($urandom_range(0, 65535)) - 32768,
						$urandom_range(0, 7) == 0);
				cnt += steps;
			end
		end
	endtask

	// hold off until every sample is sent and every result is back
	task automatic drain();
		while (sample_q.size() != 0 || holding || drive_expect.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	always @(posedge clk) begin : tx_side
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				drive_expect.push_back(advance_loop(cur_sample));
				holding = 1'b0;
			end
			if (!holding) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					cur_sample = sample_q.pop_front();
					holding = 1'b1;
					measured_position <= cur_sample.meas;
					start_req <= cur_sample.start;
					in_valid <= 1'b1;
					tx_wait = next_gap(tx_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : rx_side
		loop_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_expect.size() == 0) begin
					$error("unexpected transaction: drive_pct %0d done_res %0d",
						drive_pct, done_res);
					fail_cnt++;
				end else begin
					want = drive_expect.pop_front();
					if (drive_pct !== want.drive) begin
						$error("drive_pct: expected %0d, actual %0d",
							$signed(want.drive), drive_pct);
						fail_cnt++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %0d, actual %0d", want.done, done_res);
						fail_cnt++;
					end
				end
				rx_wait = next_gap(rx_calm);
			end else if (out_ready && $urandom_range(0, 15) == 0) begin
				rx_wait = next_gap(rx_calm);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: target 0, error = measured, window 5.0, band 1.5
		add_sample(32767, 1'b1);
		add_sample(-32768, 1'b0);
		add_sample(100, 1'b0);
		add_sample(60, 1'b0);
		add_sample(40, 1'b0);
		add_sample(-50, 1'b0);
		add_sample(10, 1'b0);
		add_sample(32767, 1'b0);
		add_sample(-32768, 1'b0);
		add_sample(500, 1'b1);
		add_sample(-70, 1'b0);
		add_sample(-30, 1'b0);
		add_sample(-23, 1'b0);
		add_sample(24, 1'b1);
		add_sample(-24, 1'b0);
		add_sample(79, 1'b0);
		add_sample(-80, 1'b0);
		add_sample(81, 1'b0);
		add_sample(0, 1'b1);
		add_sample(0, 1'b1);
		add_sample(-1, 1'b0);
		drain();

		// full gains, widest window, no settling: drive the integral into
		// both rails, clearing it once in between
		apply_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		add_sample(0, 1'b1);
		for (k = 0; k < 280; k++)
			add_sample(-(32700 + int'($urandom_range(0, 66))), 1'b0);
		add_sample(-32767, 1'b0);
		for (k = 0; k < 280; k++)
			add_sample(32700 + int'($urandom_range(0, 66)), 1'b0);
		add_sample(32767, 1'b0);
		add_sample(-32768, 1'b0);
		drain();

		repeat (6) begin
			shuffle_config();
			queue_random(130);
			drain();
		end

		// zero gains, no window, widest band at the top target
		apply_config(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0001);
		for (k = 0; k < 100; k++)
			add_sample(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 2) == 0);
		drain();

		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
